FILE: hdl/flvmd_pkg.sv
// ----------------------------------------------------------------------------
// flvmd_pkg
// shared types, property codes and key table of the script tag parser
// ----------------------------------------------------------------------------
`default_nettype none
package flvmd_pkg;

  typedef enum logic [4:0] {
    PH_HDR, PH_T1, PH_S1LEN, PH_S1SKIP, PH_T2, PH_CNT, PH_NLEN, PH_NAME,
    PH_VTYPE, PH_DBL, PH_STEREO, PH_ALEN, PH_ETYPE, PH_EVAL, PH_SLEN,
    PH_SKIP, PH_DONE
  } phase_e;

  localparam logic [4:0] CODE_TYPE     = 5'd0;
  localparam logic [4:0] CODE_SIZE     = 5'd1;
  localparam logic [4:0] CODE_TIME     = 5'd2;
  localparam logic [4:0] CODE_TIME_EXT = 5'd3;
  localparam logic [4:0] CODE_STREAM   = 5'd4;
  localparam logic [4:0] CODE_META0    = 5'd5;
  localparam logic [4:0] CODE_STEREO   = 5'd14;
  localparam logic [4:0] CODE_FILEPOS  = 5'd19;
  localparam logic [4:0] CODE_KEYTIME  = 5'd20;
  localparam logic [4:0] CODE_COUNT    = 5'd21;
  localparam logic [4:0] CODE_END      = 5'd22;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  localparam logic [7:0] AMF_NUMBER  = 8'h00;
  localparam logic [7:0] AMF_BOOL    = 8'h01;
  localparam logic [7:0] AMF_STRING  = 8'h02;
  localparam logic [7:0] AMF_OBJECT  = 8'h03;
  localparam logic [7:0] AMF_MOVIE   = 8'h04;
  localparam logic [7:0] AMF_REF     = 8'h07;
  localparam logic [7:0] AMF_ECMA    = 8'h08;
  localparam logic [7:0] AMF_OBJ_END = 8'h09;
  localparam logic [7:0] AMF_STRICT  = 8'h0A;
  localparam logic [7:0] AMF_DATE    = 8'h0B;
  localparam logic [7:0] AMF_LSTRING = 8'h0C;

  // keys 0..13 are the metadata keys, 14 filepositions, 15 times
  localparam int KEY_NUM     = 16;
  localparam int KEY_MAX_LEN = 16;
  localparam int KEY_STEREO  = 9;
  localparam int KEY_FILEPOS = 14;
  localparam int KEY_TIMES   = 15;

  typedef struct packed {
    logic [4:0]  prop_code;
    logic [63:0] prop_value;
    logic [31:0] element_index;
    logic [1:0]  parse_status;
    logic        final_result;
  } result_t;

  function automatic logic [127:0] key_str(input int k);
    logic [127:0] s;
    unique case (k)
      0:  s = 128'("duration");
      1:  s = 128'("width");
      2:  s = 128'("height");
      3:  s = 128'("videodatarate");
      4:  s = 128'("framerate");
      5:  s = 128'("videocodecid");
      6:  s = 128'("audiosamplerate");
      7:  s = 128'("audiodatarate");
      8:  s = 128'("audiosamplesize");
      9:  s = 128'("stereo");
      10: s = 128'("audiocodecid");
      11: s = 128'("filesize");
      12: s = 128'("lasttime");
      13: s = 128'("lastkeyframetime");
      14: s = 128'("filepositions");
      default: s = 128'("times");
    endcase
    return s;
  endfunction

  function automatic int key_len(input int k);
    logic [127:0] s;
    int n;
    s = key_str(k);
    n = 0;
    for (int j = 0; j < KEY_MAX_LEN; j++) begin
      if (s[8*j +: 8] != 8'd0) n = j + 1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/flvmd_in_if.sv
// ----------------------------------------------------------------------------
// flvmd_in_if
// byte channel into the parser
// ----------------------------------------------------------------------------
`default_nettype none
interface flvmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/flvmd_out_if.sv
// ----------------------------------------------------------------------------
// flvmd_out_if
// result channel out of the parser
// ----------------------------------------------------------------------------
`default_nettype none
interface flvmd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  prop_code;
  logic [63:0] prop_value;
  logic [31:0] element_index;
  logic [1:0]  parse_status;
  logic        final_result;
  modport source (output valid, prop_code, prop_value, element_index, parse_status,
                  final_result, input ready);
  modport sink (input valid, prop_code, prop_value, element_index, parse_status,
                final_result, output ready);
endinterface
`default_nettype wire

FILE: hdl/flv_script_metadata_parser_core.sv
// ----------------------------------------------------------------------------
// flv_script_metadata_parser_core
// onMetaData script tag parser, one byte per transfer
// ----------------------------------------------------------------------------
// usage:
//   in_i carries the tag bytes, last_byte marks the final byte of a tag
//   out_o returns property results: header fields, the ecma entry count,
//   raw double bits of known keys, stereo byte, keyframe array elements
//   with their index, and one end-of-tag result with the parse status
// latency: a byte is parsed in its transfer cycle and its result sits in
//   the output register the next cycle
// throughput: one byte per cycle while results are drained; a byte that
//   yields a result holds off input until that result is taken, and
//   the final byte of a tag with a property result queues the end result
// key matching runs a byte-serial prefix matcher as name bytes arrive, so
//   the value type byte finds the key hits ready
// reset: the parser waits for the first header byte; the end-of-tag
//   transfer returns all state to the same point
// stall: while a result waits in the output register no byte is accepted
// ----------------------------------------------------------------------------
`default_nettype none
module flv_script_metadata_parser_core
  import flvmd_pkg::*;
#(
  parameter int NAME_BYTES  = 32,
  parameter int MAX_NESTING = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  flvmd_in_if.sink   in_i,
  flvmd_out_if.source out_o
);

  localparam int PW = $clog2(NAME_BYTES + 1);

  phase_e         phase_q, phase_d;
  logic [31:0]    cnt_q, cnt_d;
  logic [63:0]    acc_q, acc_d;
  logic [31:0]    entries_q, entries_d;
  logic [31:0]    ael_q, ael_d;
  logic [31:0]    aei_q, aei_d;
  logic [2:0]     depth_q, depth_d;
  logic [4:0]     cur_q, cur_d;
  logic           err_q, err_d;
  logic           nlen_zero_q, nlen_zero_d;
  logic [PW-1:0]  npos_q, npos_d;

  result_t        out_q, res;
  logic           out_valid_q;
  logic           pend_q;
  logic [1:0]     pend_st_q;
  logic           have_res;
  logic           accept;
  logic           m_clear, m_shift;
  logic [KEY_NUM-1:0] hit;
  logic [63:0]    acc_take;
  logic [31:0]    cnt_dec;
  logic           take_done;
  logic           ent_done;
  logic [1:0]     end_st;
  logic [7:0]     b;
  logic           meta_hit;
  logic [4:0]     meta_code;
  logic           meta_stereo;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q;
  assign b = in_i.data_byte;

  flvmd_key_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(m_clear),
    .shift_i(m_shift),
    .byte_i (b),
    .hit_o  (hit)
  );

  // first metadata key in priority order
  always_comb begin
    meta_hit = 1'b0;
    meta_code = CODE_META0;
    meta_stereo = 1'b0;
    for (int k = KEY_FILEPOS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        meta_hit = 1'b1;
        meta_code = CODE_META0 + 5'(k);
        meta_stereo = (k == KEY_STEREO);
      end
    end
  end

  assign acc_take  = {acc_q[55:0], b};
  assign cnt_dec   = (cnt_q != '0) ? cnt_q - 32'd1 : '0;
  assign take_done = (cnt_dec == '0);

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; acc_d = acc_q; entries_d = entries_q;
    ael_d = ael_q; aei_d = aei_q; depth_d = depth_q; cur_d = cur_q;
    err_d = err_q; nlen_zero_d = nlen_zero_q; npos_d = npos_q;
    res = '0; have_res = 1'b0; ent_done = 1'b0;
    m_clear = 1'b0; m_shift = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_HDR: begin
          if (cnt_q == 32'd1 || cnt_q == 32'd4 || cnt_q == 32'd8) acc_d = {56'd0, b};
          else acc_d = acc_take;
          have_res = 1'b1;
          res.prop_value = {40'd0, acc_d[23:0]};
          priority case (cnt_q)
            32'd0:  begin res.prop_code = CODE_TYPE; res.prop_value = {56'd0, b}; end
            32'd3:  res.prop_code = CODE_SIZE;
            32'd6:  res.prop_code = CODE_TIME;
            32'd7:  begin res.prop_code = CODE_TIME_EXT; res.prop_value = {56'd0, b}; end
            32'd10: res.prop_code = CODE_STREAM;
            default: have_res = 1'b0;
          endcase
          if (cnt_q >= 32'd10) begin
            phase_d = PH_T1; cnt_d = '0; acc_d = '0;
          end else cnt_d = cnt_q + 32'd1;
        end
        PH_T1: begin
          if (b == AMF_STRING) begin
            phase_d = PH_S1LEN; cnt_d = 32'd2; acc_d = '0;
          end else phase_d = PH_T2;
        end
        PH_S1LEN: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            if (acc_take[15:0] == '0) phase_d = PH_T2;
            else begin phase_d = PH_S1SKIP; cnt_d = {16'd0, acc_take[15:0]}; acc_d = '0; end
          end
        end
        PH_S1SKIP: begin
          cnt_d = cnt_dec;
          if (take_done) phase_d = PH_T2;
        end
        PH_T2: begin
          if (b == AMF_ECMA) begin
            phase_d = PH_CNT; cnt_d = 32'd4; acc_d = '0;
          end else phase_d = PH_DONE;
        end
        PH_CNT: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            entries_d = acc_take[31:0];
            have_res = 1'b1;
            res.prop_code = CODE_COUNT;
            res.prop_value = {32'd0, acc_take[31:0]};
            if (acc_take[31:0] == '0) phase_d = PH_DONE;
            else begin phase_d = PH_NLEN; cnt_d = 32'd2; acc_d = '0; end
          end
        end
        PH_NLEN: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            m_clear = 1'b1;
            npos_d = '0;
            nlen_zero_d = (acc_take[15:0] == '0);
            if (acc_take[15:0] == '0) phase_d = PH_VTYPE;
            else begin phase_d = PH_NAME; cnt_d = {16'd0, acc_take[15:0]}; acc_d = '0; end
          end
        end
        PH_NAME: begin
          if (32'(npos_q) < NAME_BYTES) begin
            m_shift = 1'b1;
            npos_d = npos_q + PW'(1);
          end
          cnt_d = cnt_dec;
          if (take_done) phase_d = PH_VTYPE;
        end
        PH_VTYPE: begin
          if (nlen_zero_q && b == AMF_OBJ_END) begin
            if (depth_q == '0) phase_d = PH_DONE;
            else begin depth_d = depth_q - 3'd1; ent_done = 1'b1; end
          end else if (meta_hit) begin
            cur_d = meta_code; acc_d = '0;
            if (meta_stereo) begin phase_d = PH_STEREO; cnt_d = 32'd1; end
            else begin phase_d = PH_DBL; cnt_d = 32'd8; end
          end else if (b == AMF_STRICT && hit[KEY_FILEPOS]) begin
            cur_d = CODE_FILEPOS; phase_d = PH_ALEN; cnt_d = 32'd4; acc_d = '0;
          end else if (b == AMF_STRICT && hit[KEY_TIMES]) begin
            cur_d = CODE_KEYTIME; phase_d = PH_ALEN; cnt_d = 32'd4; acc_d = '0;
          end else begin
            priority case (b)
              AMF_NUMBER: begin phase_d = PH_SKIP; cnt_d = 32'd8; acc_d = '0; end
              AMF_BOOL:   begin phase_d = PH_SKIP; cnt_d = 32'd1; acc_d = '0; end
              AMF_STRING: begin phase_d = PH_SLEN; cnt_d = 32'd2; acc_d = '0; end
              AMF_OBJECT: begin
                if (32'(depth_q) >= MAX_NESTING) begin
                  err_d = 1'b1; phase_d = PH_DONE;
                end else begin
                  depth_d = depth_q + 3'd1; phase_d = PH_NLEN; cnt_d = 32'd2; acc_d = '0;
                end
              end
              AMF_MOVIE, AMF_ECMA, AMF_LSTRING: begin err_d = 1'b1; phase_d = PH_DONE; end
              AMF_REF:    begin phase_d = PH_SKIP; cnt_d = 32'd2; acc_d = '0; end
              AMF_STRICT: begin phase_d = PH_SKIP; cnt_d = 32'd4; acc_d = '0; end
              AMF_DATE:   begin phase_d = PH_SKIP; cnt_d = 32'd10; acc_d = '0; end
              default:    ent_done = 1'b1;
            endcase
          end
        end
        PH_DBL: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            have_res = 1'b1; res.prop_code = cur_q; res.prop_value = acc_take;
            ent_done = 1'b1;
          end
        end
        PH_STEREO: begin
          have_res = 1'b1; res.prop_code = CODE_STEREO; res.prop_value = {56'd0, b};
          ent_done = 1'b1;
        end
        PH_ALEN: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            ael_d = acc_take[31:0]; aei_d = '0;
            if (acc_take[31:0] == '0) ent_done = 1'b1;
            else phase_d = PH_ETYPE;
          end
        end
        PH_ETYPE: begin phase_d = PH_EVAL; cnt_d = 32'd8; acc_d = '0; end
        PH_EVAL: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            have_res = 1'b1; res.prop_code = cur_q; res.prop_value = acc_take;
            res.element_index = aei_q;
            aei_d = aei_q + 32'd1;
            ael_d = (ael_q != '0) ? ael_q - 32'd1 : '0;
            if (ael_d == '0) ent_done = 1'b1;
            else phase_d = PH_ETYPE;
          end
        end
        PH_SLEN: begin
          acc_d = acc_take; cnt_d = cnt_dec;
          if (take_done) begin
            if (acc_take[15:0] == '0) ent_done = 1'b1;
            else begin phase_d = PH_SKIP; cnt_d = {16'd0, acc_take[15:0]}; acc_d = '0; end
          end
        end
        PH_SKIP: begin
          cnt_d = cnt_dec;
          if (take_done) ent_done = 1'b1;
        end
        default: phase_d = PH_DONE;
      endcase

      // entry closes: top-level entries count against the ecma count
      if (ent_done) begin
        if (depth_d == '0 && entries_q <= 32'd1) begin
          entries_d = '0; phase_d = PH_DONE;
        end else begin
          if (depth_d == '0) entries_d = entries_q - 32'd1;
          phase_d = PH_NLEN; cnt_d = 32'd2; acc_d = '0;
        end
      end
    end
  end

  assign end_st = err_d ? ST_UNSUP : ((phase_d == PH_DONE) ? ST_OK : ST_EARLY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; cnt_q <= '0; acc_q <= '0; entries_q <= '0;
      ael_q <= '0; aei_q <= '0; depth_q <= '0; cur_q <= '0; err_q <= 1'b0;
      nlen_zero_q <= 1'b1; npos_q <= '0;
    end else if (accept && in_i.last_byte) begin
      phase_q <= PH_HDR; cnt_q <= '0; acc_q <= '0; entries_q <= '0;
      ael_q <= '0; aei_q <= '0; depth_q <= '0; cur_q <= '0; err_q <= 1'b0;
      nlen_zero_q <= 1'b1; npos_q <= '0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; acc_q <= acc_d; entries_q <= entries_d;
      ael_q <= ael_d; aei_q <= aei_d; depth_q <= depth_d; cur_q <= cur_d;
      err_q <= err_d; nlen_zero_q <= nlen_zero_d; npos_q <= npos_d;
    end
  end

  // output register with one pending end-of-tag result behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0; pend_q <= 1'b0; pend_st_q <= ST_OK;
    end else if (accept) begin
      if (have_res) begin
        out_valid_q <= 1'b1;
        pend_q <= in_i.last_byte;
        pend_st_q <= end_st;
      end else if (in_i.last_byte) begin
        out_valid_q <= 1'b1;
      end
    end else if (out_valid_q && out_o.ready) begin
      if (pend_q) pend_q <= 1'b0;
      else out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (have_res) out_q <= res;
      else if (in_i.last_byte) out_q <= '{CODE_END, 64'd0, 32'd0, end_st, 1'b1};
    end else if (out_valid_q && out_o.ready && pend_q) begin
      out_q <= '{CODE_END, 64'd0, 32'd0, pend_st_q, 1'b1};
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.prop_code     = out_q.prop_code;
  assign out_o.prop_value    = out_q.prop_value;
  assign out_o.element_index = out_q.element_index;
  assign out_o.parse_status  = out_q.parse_status;
  assign out_o.final_result  = out_q.final_result;

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q) else $error("pending end result without held result");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !accept) else $error("byte accepted while result held");
  a_final_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.final_result) |-> (out_q.prop_code == CODE_END))
    else $error("end flag on a property result");
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last_byte) |=> (phase_q == PH_HDR && depth_q == '0))
    else $error("parser not back at header after tag end");

endmodule
`default_nettype wire

FILE: hdl/flvmd_key_match.sv
// ----------------------------------------------------------------------------
// flvmd_key_match
// substring matcher, one name byte per step against all keys
// ----------------------------------------------------------------------------
`default_nettype none
module flvmd_key_match
  import flvmd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  input  wire logic               shift_i,
  input  wire logic [7:0]         byte_i,
  output logic [KEY_NUM-1:0]      hit_o
);

  logic [KEY_MAX_LEN-1:0] pfx_q [KEY_NUM];
  logic [KEY_MAX_LEN-1:0] pfx_d [KEY_NUM];
  logic [KEY_NUM-1:0]     hit_q, hit_d;

  // prefix bit j of key k: the last j+1 bytes equal the first j+1 key bytes
  always_comb begin
    logic [127:0] ks;
    int           kl;
    hit_d = hit_q;
    for (int k = 0; k < KEY_NUM; k++) begin
      ks = key_str(k);
      kl = key_len(k);
      pfx_d[k] = '0;
      for (int j = 0; j < KEY_MAX_LEN; j++) begin
        if (j < kl) begin
          pfx_d[k][j] = ((j == 0) ? 1'b1 : pfx_q[k][(j == 0) ? 0 : j-1]) &&
                        (byte_i == ks[8*(kl-1-j) +: 8]);
        end
      end
      if (pfx_d[k][kl-1]) hit_d[k] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
      for (int k = 0; k < KEY_NUM; k++) pfx_q[k] <= '0;
    end else if (clear_i) begin
      hit_q <= '0;
      for (int k = 0; k < KEY_NUM; k++) pfx_q[k] <= '0;
    end else if (shift_i) begin
      hit_q <= hit_d;
      for (int k = 0; k < KEY_NUM; k++) pfx_q[k] <= pfx_d[k];
    end
  end

  assign hit_o = hit_q;

endmodule
`default_nettype wire

FILE: tb/tb_flv_script_metadata_parser_core.sv
// ----------------------------------------------------------------------------
// tb_flv_script_metadata_parser_core
// self-checking bench: builds script tags byte by byte and compares every
// result transfer against a cycle-free parse of the same bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_flv_script_metadata_parser_core;
  import flvmd_pkg::*;

  localparam int NAME_BYTES  = 32;
  localparam int MAX_NESTING = 4;

  logic clk_i;
  logic rst_ni;

  flvmd_in_if  in_if ();
  flvmd_out_if out_if ();

  flv_script_metadata_parser_core #(
    .NAME_BYTES (NAME_BYTES),
    .MAX_NESTING(MAX_NESTING)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock; the one reset at the start comes from the main initial block
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parse model state
  // ---------------------------------------------------------------------------
  string meta_keys[14] = '{"duration", "width", "height", "videodatarate",
    "framerate", "videocodecid", "audiosamplerate", "audiodatarate",
    "audiosamplesize", "stereo", "audiocodecid", "filesize", "lasttime",
    "lastkeyframetime"};

  phase_e      pm_phase;
  logic [31:0] pm_count;
  logic [7:0]  pm_name [NAME_BYTES];
  logic [31:0] pm_nlen;
  logic [63:0] pm_acc;
  logic [31:0] pm_entries;
  logic [31:0] pm_elems;
  logic [31:0] pm_eidx;
  int          pm_depth;
  logic [4:0]  pm_prop;
  logic        pm_err;

  result_t expected_q[$];
  int      n_err;
  int      n_bytes;
  int      n_results;
  int      n_tags;

  task automatic pm_reset();
    pm_phase   = PH_HDR;
    pm_count   = '0;
    pm_nlen    = '0;
    pm_acc     = '0;
    pm_entries = '0;
    pm_elems   = '0;
    pm_eidx    = '0;
    pm_depth   = 0;
    pm_prop    = '0;
    pm_err     = 1'b0;
  endtask

  task automatic push_result(logic [4:0] code, logic [63:0] val, logic [31:0] idx,
                             logic [1:0] st, logic fin);
    result_t r;
    r.prop_code     = code;
    r.prop_value    = val;
    r.element_index = idx;
    r.parse_status  = st;
    r.final_result  = fin;
    expected_q.push_back(r);
  endtask

  task automatic pm_go(phase_e ph, logic [31:0] cnt);
    pm_phase = ph;
    pm_count = cnt;
    pm_acc   = '0;
  endtask

  function automatic logic pm_take(logic [7:0] b);
    pm_acc = {pm_acc[55:0], b};
    if (pm_count > 0) pm_count--;
    return pm_count == 0;
  endfunction

  function automatic logic name_contains(string key);
    int kl;
    int nl;
    logic hit;
    kl = key.len();
    nl = (pm_nlen < NAME_BYTES) ? int'(pm_nlen) : NAME_BYTES;
    if (kl == 0 || kl > nl) return 1'b0;
    for (int i = 0; i + kl <= nl; i++) begin
      hit = 1'b1;
      for (int j = 0; j < kl; j++)
        if (pm_name[i+j] != key[j]) hit = 1'b0;
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  // one entry finished: top-level entries count down the ecma count
  task automatic pm_entry_done();
    if (pm_depth == 0) begin
      if (pm_entries > 0) pm_entries--;
      if (pm_entries == 0) begin
        pm_phase = PH_DONE;
        return;
      end
    end
    pm_go(PH_NLEN, 2);
  endtask

  task automatic pm_fail();
    pm_err   = 1'b1;
    pm_phase = PH_DONE;
  endtask

  task automatic pm_value_type(logic [7:0] b);
    // empty name with object end closes a level or the whole parse
    if (pm_nlen == 0 && b == AMF_OBJ_END) begin
      if (pm_depth == 0) pm_phase = PH_DONE;
      else begin
        pm_depth--;
        pm_entry_done();
      end
      return;
    end
    // metadata keys win in code order, whatever the type byte says
    for (int i = 0; i < 14; i++) begin
      if (name_contains(meta_keys[i])) begin
        pm_prop = CODE_META0 + 5'(i);
        if (i == 9) pm_go(PH_STEREO, 1);
        else pm_go(PH_DBL, 8);
        return;
      end
    end
    if (b == AMF_STRICT && name_contains("filepositions")) begin
      pm_prop = CODE_FILEPOS;
      pm_go(PH_ALEN, 4);
      return;
    end
    if (b == AMF_STRICT && name_contains("times")) begin
      pm_prop = CODE_KEYTIME;
      pm_go(PH_ALEN, 4);
      return;
    end
    case (b)
      AMF_NUMBER: pm_go(PH_SKIP, 8);
      AMF_BOOL:   pm_go(PH_SKIP, 1);
      AMF_STRING: pm_go(PH_SLEN, 2);
      AMF_OBJECT: begin
        if (pm_depth >= MAX_NESTING) pm_fail();
        else begin
          pm_depth++;
          pm_go(PH_NLEN, 2);
        end
      end
      AMF_MOVIE, AMF_ECMA, AMF_LSTRING: pm_fail();
      AMF_REF:    pm_go(PH_SKIP, 2);
      AMF_STRICT: pm_go(PH_SKIP, 4);
      AMF_DATE:   pm_go(PH_SKIP, 10);
      default:    pm_entry_done();
    endcase
  endtask

  task automatic pm_header(logic [7:0] b);
    logic [31:0] pos;
    pos = pm_count;
    if (pos == 1 || pos == 4 || pos == 8) pm_acc = {56'd0, b};
    else pm_acc = {pm_acc[55:0], b};
    case (pos)
      0:  push_result(CODE_TYPE, {56'd0, b}, '0, ST_OK, 1'b0);
      3:  push_result(CODE_SIZE, {40'd0, pm_acc[23:0]}, '0, ST_OK, 1'b0);
      6:  push_result(CODE_TIME, {40'd0, pm_acc[23:0]}, '0, ST_OK, 1'b0);
      7:  push_result(CODE_TIME_EXT, {56'd0, b}, '0, ST_OK, 1'b0);
      10: push_result(CODE_STREAM, {40'd0, pm_acc[23:0]}, '0, ST_OK, 1'b0);
      default: ;
    endcase
    if (pos >= 10) pm_go(PH_T1, 0);
    else pm_count = pos + 1;
  endtask

  // predicted results of one accepted byte
  task automatic parse_byte(logic [7:0] b, logic last);
    logic [31:0] len;
    logic [31:0] idx;
    case (pm_phase)
      PH_HDR: pm_header(b);
      PH_T1: begin
        if (b == AMF_STRING) pm_go(PH_S1LEN, 2);
        else pm_phase = PH_T2;
      end
      PH_S1LEN: begin
        if (pm_take(b)) begin
          len = {16'd0, pm_acc[15:0]};
          if (len == 0) pm_phase = PH_T2;
          else pm_go(PH_S1SKIP, len);
        end
      end
      PH_S1SKIP: begin
        if (pm_count > 0) pm_count--;
        if (pm_count == 0) pm_phase = PH_T2;
      end
      PH_T2: begin
        if (b == AMF_ECMA) pm_go(PH_CNT, 4);
        else pm_phase = PH_DONE;
      end
      PH_CNT: begin
        if (pm_take(b)) begin
          pm_entries = pm_acc[31:0];
          push_result(CODE_COUNT, {32'd0, pm_entries}, '0, ST_OK, 1'b0);
          if (pm_entries == 0) pm_phase = PH_DONE;
          else pm_go(PH_NLEN, 2);
        end
      end
      PH_NLEN: begin
        if (pm_take(b)) begin
          pm_nlen = {16'd0, pm_acc[15:0]};
          if (pm_nlen == 0) pm_phase = PH_VTYPE;
          else pm_go(PH_NAME, pm_nlen);
        end
      end
      PH_NAME: begin
        idx = pm_nlen - pm_count;
        if (idx < NAME_BYTES) pm_name[idx] = b;
        if (pm_count > 0) pm_count--;
        if (pm_count == 0) pm_phase = PH_VTYPE;
      end
      PH_VTYPE: pm_value_type(b);
      PH_DBL: begin
        if (pm_take(b)) begin
          push_result(pm_prop, pm_acc, '0, ST_OK, 1'b0);
          pm_entry_done();
        end
      end
      PH_STEREO: begin
        push_result(CODE_STEREO, {56'd0, b}, '0, ST_OK, 1'b0);
        pm_entry_done();
      end
      PH_ALEN: begin
        if (pm_take(b)) begin
          pm_elems = pm_acc[31:0];
          pm_eidx  = '0;
          if (pm_elems == 0) pm_entry_done();
          else pm_phase = PH_ETYPE;
        end
      end
      PH_ETYPE: pm_go(PH_EVAL, 8);
      PH_EVAL: begin
        if (pm_take(b)) begin
          push_result(pm_prop, pm_acc, pm_eidx, ST_OK, 1'b0);
          pm_eidx++;
          if (pm_elems > 0) pm_elems--;
          if (pm_elems == 0) pm_entry_done();
          else pm_phase = PH_ETYPE;
        end
      end
      PH_SLEN: begin
        if (pm_take(b)) begin
          len = {16'd0, pm_acc[15:0]};
          if (len == 0) pm_entry_done();
          else pm_go(PH_SKIP, len);
        end
      end
      PH_SKIP: begin
        if (pm_count > 0) pm_count--;
        if (pm_count == 0) pm_entry_done();
      end
      default: pm_phase = PH_DONE;
    endcase
    if (last) begin
      push_result(CODE_END, '0, '0,
                  pm_err ? ST_UNSUP : (pm_phase == PH_DONE ? ST_OK : ST_EARLY), 1'b1);
      pm_reset();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts with random gaps, or back to back when steady_send is set
  // ---------------------------------------------------------------------------
  int burst_left;
  bit steady_send;

  task automatic xfer_byte(logic [7:0] b, logic last);
    int gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    parse_byte(b, last);
    n_bytes++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int ready_pct;
  bit hold_req;
  int hold_left;

  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected, code %0d", out_if.prop_code);
        n_err++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.prop_code !== e.prop_code) begin
          $error("prop_code: expected %0d, actual %0d", e.prop_code, out_if.prop_code);
          n_err++;
        end
        if (out_if.prop_value !== e.prop_value) begin
          $error("prop_value: expected %h, actual %h", e.prop_value, out_if.prop_value);
          n_err++;
        end
        if (out_if.element_index !== e.element_index) begin
          $error("element_index: expected %0d, actual %0d", e.element_index,
                 out_if.element_index);
          n_err++;
        end
        if (out_if.parse_status !== e.parse_status) begin
          $error("parse_status: expected %0d, actual %0d", e.parse_status,
                 out_if.parse_status);
          n_err++;
        end
        if (out_if.final_result !== e.final_result) begin
          $error("final_result: expected %0d, actual %0d", e.final_result,
                 out_if.final_result);
          n_err++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tag building
  // ---------------------------------------------------------------------------
  logic [7:0] tag_q[$];

  task automatic put_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) tag_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_name(string s);
    put_be(64'(s.len()), 2);
    for (int i = 0; i < s.len(); i++) tag_q.push_back(s[i]);
  endtask

  function automatic string rand_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h61, 8'h7a)))};
    return s;
  endfunction

  task automatic put_header(logic [7:0] fill);
    for (int i = 0; i < 11; i++)
      tag_q.push_back((fill == 8'h5a) ? 8'($urandom) : fill);
  endtask

  task automatic put_preamble(logic [31:0] count);
    tag_q.push_back(AMF_STRING);
    put_name("onMetaData");
    tag_q.push_back(AMF_ECMA);
    put_be(64'(count), 4);
  endtask

  task automatic put_end_marker();
    put_be(0, 2);
    tag_q.push_back(AMF_OBJ_END);
  endtask

  task automatic put_array(string name, int n);
    put_name(name);
    tag_q.push_back(AMF_STRICT);
    put_be(64'(n), 4);
    for (int i = 0; i < n; i++) begin
      tag_q.push_back(8'($urandom));
      put_be({$urandom, $urandom}, 8);
    end
  endtask

  // one random entry, mostly well formed
  task automatic put_entry(int depth);
    int r;
    int k;
    logic [7:0] t;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      k = $urandom_range(0, 13);
      case ($urandom_range(0, 3))
        0: put_name({rand_word($urandom_range(1, 4)), meta_keys[k]});
        1: put_name({meta_keys[k], "_", rand_word(2)});
        default: put_name(meta_keys[k]);
      endcase
      tag_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : AMF_NUMBER);
      if (k == 9) tag_q.push_back(8'($urandom));
      else put_be({$urandom, $urandom}, 8);
    end else if (r < 60) begin
      put_array(($urandom_range(0, 1) == 0) ? "filepositions" : "times",
                $urandom_range(0, 3));
    end else if (r < 82) begin
      put_name(rand_word(($urandom_range(0, 5) == 0) ? $urandom_range(33, 45)
                                                     : $urandom_range(1, 12)));
      case ($urandom_range(0, 7))
        0: t = AMF_NUMBER;
        1: t = AMF_BOOL;
        2: t = AMF_STRING;
        3: t = AMF_REF;
        4: t = AMF_STRICT;
        5: t = AMF_DATE;
        6: t = 8'h05;
        default: t = 8'h0d;
      endcase
      tag_q.push_back(t);
      case (t)
        AMF_NUMBER: put_be({$urandom, $urandom}, 8);
        AMF_BOOL:   tag_q.push_back(8'($urandom));
        AMF_STRING: put_name(rand_word($urandom_range(0, 6)));
        AMF_REF:    put_be(64'($urandom), 2);
        AMF_STRICT: put_be(0, 4);
        AMF_DATE:   put_be({$urandom, $urandom}, 10);
        default: ;
      endcase
    end else if (r < 94 && depth < 5) begin
      put_name(rand_word($urandom_range(1, 6)));
      tag_q.push_back(AMF_OBJECT);
      repeat ($urandom_range(0, 3)) put_entry(depth + 1);
      put_end_marker();
    end else begin
      put_name(rand_word(3));
      case ($urandom_range(0, 2))
        0: tag_q.push_back(AMF_MOVIE);
        1: tag_q.push_back(AMF_ECMA);
        default: tag_q.push_back(AMF_LSTRING);
      endcase
    end
  endtask

  task automatic send_tag();
    for (int i = 0; i < tag_q.size(); i++)
      xfer_byte(tag_q[i], i == tag_q.size() - 1);
    tag_q.delete();
    n_tags++;
  endtask

  task automatic build_random_tag();
    int n;
    int cut;
    put_header(8'h5a);
    if ($urandom_range(0, 19) == 0) tag_q.push_back(8'($urandom));
    else tag_q.push_back(AMF_STRING);
    put_name("onMetaData");
    tag_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : AMF_ECMA);
    n = $urandom_range(1, 6);
    put_be(64'(($urandom_range(0, 4) == 0) ? n + 3 : n), 4);
    repeat (n) put_entry(0);
    if ($urandom_range(0, 1) == 0) put_end_marker();
    repeat ($urandom_range(0, 3)) tag_q.push_back(8'($urandom));
    // now and then the tag ends early
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, tag_q.size());
      while (tag_q.size() > cut) void'(tag_q.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_header_extremes();
    put_header(8'h00);
    put_preamble(0);
    send_tag();
    put_header(8'hff);
    tag_q.push_back(8'hff);
    send_tag();
    xfer_byte(8'hff, 1'b1);  // header cut after one byte
  endtask

  task automatic test_every_key();
    put_header(8'h5a);
    put_preamble(18);
    for (int k = 0; k < 14; k++) begin
      put_name(meta_keys[k]);
      tag_q.push_back(AMF_NUMBER);
      if (k == 9) tag_q.push_back(8'h01);
      else put_be({$urandom, $urandom}, 8);
    end
    put_array("keyframe_filepositions", 3);
    put_array("times", 2);
    put_array("filepositions", 0);
    // long name with a key past the stored part
    put_name({rand_word(30), "duration"});
    tag_q.push_back(AMF_NUMBER);
    put_be(64'h4024_0000_0000_0000, 8);
    send_tag();
  endtask

  task automatic test_special_cases();
    // no ecma array after the leading string
    put_header(8'h5a);
    tag_q.push_back(AMF_STRING);
    put_name("");
    tag_q.push_back(AMF_NUMBER);
    tag_q.push_back(8'h00);
    send_tag();
    // nesting past the limit is unsupported
    put_header(8'h5a);
    put_preamble(1);
    for (int d = 0; d <= MAX_NESTING; d++) begin
      put_name("o");
      tag_q.push_back(AMF_OBJECT);
    end
    send_tag();
    // the skipped types other than number, an empty object, then unsupported; next an object end at top
    put_header(8'h5a);
    put_preamble(9);
    put_name("a"); tag_q.push_back(AMF_BOOL); tag_q.push_back(8'h01);
    put_name("b"); tag_q.push_back(AMF_REF); put_be(64'h1234, 2);
    put_name("c"); tag_q.push_back(AMF_DATE); put_be(0, 10);
    put_name("d"); tag_q.push_back(AMF_STRING); put_name("xyz");
    put_name("e"); tag_q.push_back(AMF_STRICT); put_be(0, 4);
    put_name("f"); tag_q.push_back(8'h06);
    put_name("g"); tag_q.push_back(AMF_OBJECT); put_end_marker();
    put_name("h"); tag_q.push_back(AMF_MOVIE);
    tag_q.push_back(8'h77);
    send_tag();
    put_header(8'h5a);
    put_preamble(5);
    put_end_marker();
    put_be(64'hdead, 2);
    send_tag();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    steady_send = 1'b1;
    repeat (3) begin
      build_random_tag();
      send_tag();
    end
    steady_send = 1'b0;
  endtask

  task automatic test_random_tags();
    while (n_bytes < 1900) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 20;
        default: ready_pct = 70;
      endcase
      steady_send = ($urandom_range(0, 3) == 0);
      build_random_tag();
      send_tag();
    end
    steady_send = 1'b0;
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    ready_pct   = 70;
    hold_req    = 1'b0;
    hold_left   = 0;
    burst_left  = 0;
    steady_send = 1'b0;
    n_err = 0; n_bytes = 0; n_results = 0; n_tags = 0;
    for (int i = 0; i < NAME_BYTES; i++) pm_name[i] = '0;
    pm_reset();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_extremes();
    test_every_key();
    test_special_cases();
    test_backpressure();
    test_random_tags();

    in_if.valid <= 1'b0;
    ready_pct = 80;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d tags, %0d bytes, %0d results checked", n_tags, n_bytes,
             n_results);
    $display("keys, keyframe arrays, nesting, skips, unsupported and early ends");
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hdl/flvmd_pkg.sv
hdl/flvmd_in_if.sv
hdl/flvmd_out_if.sv
hdl/flvmd_key_match.sv
hdl/flv_script_metadata_parser_core.sv
tb/tb_flv_script_metadata_parser_core.sv
